>>> rtl/ppsteer_pkg.sv
// Shared types, constants and helpers for the pure pursuit steering block.
// No dependencies; used by every module under rtl.
package ppsteer_pkg;

    // Default parameters
    localparam int PATH_DEPTH_DEF   = 1024;
    localparam int CORDIC_STEPS_DEF = 16;

    // Fixed field widths
    localparam int LD_W    = 23;
    localparam int WB_W    = 20;
    localparam int CFG_W   = 23;
    localparam int IDX_W   = 10;
    localparam int COORD_W = 32;
    localparam int QUAT_W  = 16;
    localparam int STEER_W = 15;
    localparam int YAW_W   = 16;

    // CORDIC datapath widths: vector side and Q5.29 angle side
    localparam int CV_W  = 58;
    localparam int ANG_W = 34;
    localparam int TAB_IW = 5;

    // Configuration register indexes
    localparam logic CFG_LOOKAHEAD = 1'b0;
    localparam logic CFG_WHEELBASE = 1'b1;

    localparam logic [LD_W-1:0] LD_RESET = 23'd393216;
    localparam logic [WB_W-1:0] WB_RESET = 20'd197263;

    // Angles in Q29
    localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd843314857;
    localparam logic signed [ANG_W:0]   ANG_TWO_PI  = 35'sd3373259426;
    localparam logic signed [CV_W-1:0]  SIN_GAIN    = 58'sd652032875;
    localparam logic signed [17:0]      STEER_MAX   = 18'sd12868;

    // Input opcodes
    localparam logic [1:0] OP_POINT  = 2'd0;
    localparam logic [1:0] OP_ORIENT = 2'd1;
    localparam logic [1:0] OP_POS    = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // Command class after the front has looked at it
    typedef enum logic [2:0] {
        K_NOP,
        K_PATH,
        K_ORIENT,
        K_POS,
        K_TICK
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [IDX_W-1:0]           idx;
        logic                       last;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic signed [QUAT_W-1:0]   qx;
        logic signed [QUAT_W-1:0]   qy;
        logic signed [QUAT_W-1:0]   qz;
        logic signed [QUAT_W-1:0]   qw;
    } t_cmd;

    // atan(2^-i) in Q29
    function automatic logic signed [ANG_W-1:0] atan_tab(input logic [TAB_IW-1:0] i);
        logic signed [ANG_W-1:0] v;
        unique case (i)
            5'd0:  v = 34'sd421657428;
            5'd1:  v = 34'sd248918915;
            5'd2:  v = 34'sd131521918;
            5'd3:  v = 34'sd66762579;
            5'd4:  v = 34'sd33510843;
            5'd5:  v = 34'sd16771758;
            5'd6:  v = 34'sd8387925;
            5'd7:  v = 34'sd4194219;
            5'd8:  v = 34'sd2097141;
            5'd9:  v = 34'sd1048575;
            5'd10: v = 34'sd524288;
            5'd11: v = 34'sd262144;
            5'd12: v = 34'sd131072;
            5'd13: v = 34'sd65536;
            5'd14: v = 34'sd32768;
            5'd15: v = 34'sd16384;
            5'd16: v = 34'sd8192;
            5'd17: v = 34'sd4096;
            5'd18: v = 34'sd2048;
            5'd19: v = 34'sd1024;
            5'd20: v = 34'sd512;
            5'd21: v = 34'sd256;
            5'd22: v = 34'sd128;
            5'd23: v = 34'sd64;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q29 to Q13, round to nearest, ties up
    function automatic logic signed [17:0] q29_to_q13(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W:0] s;
        s = (ANG_W+1)'(a) + 35'sd32768;
        return 18'(s >>> 16);
    endfunction

endpackage

>>> rtl/ppsteer_front.sv
// Front end: takes input beats, classifies them and queues them for the back end.
// Depends on ppsteer_pkg.
module ppsteer_front #(
    parameter int PATH_DEPTH = ppsteer_pkg::PATH_DEPTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_push,
    output logic                                       o_full,
    input  logic [1:0]                                 i_op,
    input  logic [ppsteer_pkg::IDX_W-1:0]              i_point_index,
    input  logic                                       i_last_point,
    input  logic signed [ppsteer_pkg::COORD_W-1:0]     i_coord_x,
    input  logic signed [ppsteer_pkg::COORD_W-1:0]     i_coord_y,
    input  logic signed [ppsteer_pkg::QUAT_W-1:0]      i_quat_x,
    input  logic signed [ppsteer_pkg::QUAT_W-1:0]      i_quat_y,
    input  logic signed [ppsteer_pkg::QUAT_W-1:0]      i_quat_z,
    input  logic signed [ppsteer_pkg::QUAT_W-1:0]      i_quat_w,
    output logic                                       o_cmd_valid,
    output ppsteer_pkg::t_cmd                          o_cmd,
    input  logic                                       i_cmd_pop
);

    ppsteer_pkg::t_cmd r_q [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    ppsteer_pkg::t_cmd w_cmd;
    logic              w_wr, w_rd;

    // Classify: out-of-table path points become no-ops
    always_comb begin
        w_cmd.idx  = i_point_index;
        w_cmd.last = i_last_point;
        w_cmd.cx   = i_coord_x;
        w_cmd.cy   = i_coord_y;
        w_cmd.qx   = i_quat_x;
        w_cmd.qy   = i_quat_y;
        w_cmd.qz   = i_quat_z;
        w_cmd.qw   = i_quat_w;
        unique case (i_op)
            ppsteer_pkg::OP_POINT:  w_cmd.kind = (32'(i_point_index) < PATH_DEPTH) ?
                                                 ppsteer_pkg::K_PATH : ppsteer_pkg::K_NOP;
            ppsteer_pkg::OP_ORIENT: w_cmd.kind = ppsteer_pkg::K_ORIENT;
            ppsteer_pkg::OP_POS:    w_cmd.kind = ppsteer_pkg::K_POS;
            ppsteer_pkg::OP_TICK:   w_cmd.kind = ppsteer_pkg::K_TICK;
            default:                w_cmd.kind = ppsteer_pkg::K_NOP;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    // Two-entry queue
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

>>> rtl/ppsteer_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle; vectoring (atan2) or rotation (sine).
// Depends on ppsteer_pkg.
module ppsteer_cordic #(
    parameter int CORDIC_STEPS = ppsteer_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic                                    i_rotate,
    input  logic signed [ppsteer_pkg::CV_W-1:0]     i_x,
    input  logic signed [ppsteer_pkg::CV_W-1:0]     i_y,
    input  logic signed [ppsteer_pkg::ANG_W-1:0]    i_z,
    output logic                                    o_done,
    output logic signed [ppsteer_pkg::CV_W-1:0]     o_y,
    output logic signed [ppsteer_pkg::ANG_W-1:0]    o_z
);

    localparam logic [ppsteer_pkg::TAB_IW-1:0] LAST_STEP =
        ppsteer_pkg::TAB_IW'(CORDIC_STEPS - 1);

    logic signed [ppsteer_pkg::CV_W-1:0]  r_x, r_y, n_x, n_y, w_xs, w_ys;
    logic signed [ppsteer_pkg::ANG_W-1:0] r_z, n_z, w_t;
    logic [ppsteer_pkg::TAB_IW-1:0]       r_i;
    logic                                 r_busy, r_done, r_zero, r_rot, w_ccw;

    assign o_done = r_done;
    assign o_y    = r_y;
    assign o_z    = r_zero ? '0 : r_z;

    // One micro-rotation
    always_comb begin
        w_xs  = r_x >>> r_i;
        w_ys  = r_y >>> r_i;
        w_t   = ppsteer_pkg::atan_tab(r_i);
        w_ccw = r_rot ? (r_z >= 0) : !(r_y > 0);
        if (w_ccw) begin
            n_x = r_x - w_ys;
            n_y = r_y + w_xs;
            n_z = r_z - w_t;
        end else begin
            n_x = r_x + w_ys;
            n_y = r_y - w_xs;
            n_z = r_z + w_t;
        end
    end

    // Load with quadrant fold, then iterate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rot  <= i_rotate;
            r_i    <= '0;
            r_zero <= !i_rotate && (i_x == 0) && (i_y == 0);
            if (i_rotate) begin
                r_x <= ppsteer_pkg::SIN_GAIN;
                r_y <= '0;
                if (i_z > ppsteer_pkg::ANG_HALF_PI) begin
                    r_z <= ppsteer_pkg::ANG_PI - i_z;
                end else if (i_z < -ppsteer_pkg::ANG_HALF_PI) begin
                    r_z <= -ppsteer_pkg::ANG_PI - i_z;
                end else begin
                    r_z <= i_z;
                end
            end else if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x <= i_y;
                    r_y <= -i_x;
                    r_z <= ppsteer_pkg::ANG_HALF_PI;
                end else begin
                    r_x <= -i_y;
                    r_y <= i_x;
                    r_z <= -ppsteer_pkg::ANG_HALF_PI;
                end
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_i <= r_i + 1'b1;
        end
    end

    // Done stays up, with the result held, until the next start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_busy && (r_i == LAST_STEP)) begin
                r_done <= 1'b1;
            end
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_i == LAST_STEP)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/ppsteer_back.sv
// Back end: path table, vehicle state, lookahead search and steering sequencer.
// Depends on ppsteer_pkg and ppsteer_cordic.
module ppsteer_back #(
    parameter int PATH_DEPTH   = ppsteer_pkg::PATH_DEPTH_DEF,
    parameter int CORDIC_STEPS = ppsteer_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic                                     i_cfg_index,
    input  logic [ppsteer_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                     i_cmd_valid,
    input  ppsteer_pkg::t_cmd                        i_cmd,
    output logic                                     o_cmd_pop,
    output logic                                     o_empty,
    input  logic                                     i_pop,
    output logic signed [ppsteer_pkg::STEER_W-1:0]   o_steering,
    output logic [ppsteer_pkg::IDX_W-1:0]            o_target_index
);

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int LW = AW + 1;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_Q1    = 15'b000000000000010,
        S_Q2    = 15'b000000000000100,
        S_YS    = 15'b000000000001000,
        S_YAW   = 15'b000000000010000,
        S_RD    = 15'b000000000100000,
        S_DIFF  = 15'b000000001000000,
        S_SQR   = 15'b000000010000000,
        S_CMP   = 15'b000000100000000,
        S_BS    = 15'b000001000000000,
        S_BEAR  = 15'b000010000000000,
        S_SS    = 15'b000100000000000,
        S_SIN   = 15'b001000000000000,
        S_TS    = 15'b010000000000000,
        S_STEER = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    // Config and vehicle state
    logic [ppsteer_pkg::LD_W-1:0]           r_ld;
    logic [ppsteer_pkg::WB_W-1:0]           r_wb;
    logic [2*ppsteer_pkg::LD_W-1:0]         r_ld2;
    logic signed [ppsteer_pkg::COORD_W-1:0] r_vx, r_vy;
    logic signed [ppsteer_pkg::YAW_W-1:0]   r_yaw;
    logic                                   r_path_valid, r_pos_valid;
    logic [LW-1:0]                          r_plen, r_idx;
    logic [AW-1:0]                          r_ss;

    // Path table
    logic signed [ppsteer_pkg::COORD_W-1:0] r_mem_x [PATH_DEPTH];
    logic signed [ppsteer_pkg::COORD_W-1:0] r_mem_y [PATH_DEPTH];
    logic signed [ppsteer_pkg::COORD_W-1:0] r_rd_x, r_rd_y;
    logic                                   w_mem_we;

    // Datapath registers
    ppsteer_pkg::t_cmd                      r_cmd;
    logic signed [2*ppsteer_pkg::QUAT_W-1:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [ppsteer_pkg::COORD_W:0]   r_dx, r_dy, w_dx, w_dy;
    logic [ppsteer_pkg::COORD_W-1:0]        r_mx, r_my;
    logic [2*ppsteer_pkg::COORD_W-1:0]      r_sx, r_sy;
    logic [2*ppsteer_pkg::COORD_W:0]        w_sum;
    logic                                   w_far;
    logic signed [ppsteer_pkg::ANG_W-1:0]   r_alpha;
    logic signed [ppsteer_pkg::ANG_W:0]     w_a0, w_a1, w_a2;
    logic signed [ppsteer_pkg::CV_W-1:0]    r_num;
    logic signed [ppsteer_pkg::CV_W-1:0]    w_sin;
    logic signed [17:0]                     w_rnd;

    // Output slot
    logic                                   r_out_valid;
    logic signed [ppsteer_pkg::STEER_W-1:0] r_steer;
    logic [ppsteer_pkg::IDX_W-1:0]          r_tidx;

    // CORDIC hookup
    logic                                   c_start, c_rot, c_done;
    logic signed [ppsteer_pkg::CV_W-1:0]    c_x, c_y, c_yo;
    logic signed [ppsteer_pkg::ANG_W-1:0]   c_z, c_zo;

    ppsteer_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (c_start),
        .i_rotate (c_rot),
        .i_x      (c_x),
        .i_y      (c_y),
        .i_z      (c_z),
        .o_done   (c_done),
        .o_y      (c_yo),
        .o_z      (c_zo)
    );

    assign o_empty        = !r_out_valid;
    assign o_steering     = r_steer;
    assign o_target_index = r_tidx;
    assign o_cmd_pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign w_mem_we       = o_cmd_pop && (i_cmd.kind == ppsteer_pkg::K_PATH);

    // CORDIC operand select
    always_comb begin
        c_start = 1'b0;
        c_rot   = 1'b0;
        c_x     = '0;
        c_y     = '0;
        c_z     = r_alpha;
        unique case (r_state)
            S_YS: begin
                c_start = 1'b1;
                c_y = ppsteer_pkg::CV_W'(r_p1 + r_p2) <<< 1;
                c_x = (ppsteer_pkg::CV_W'(1) <<< 28) - (ppsteer_pkg::CV_W'(r_p3 + r_p4) <<< 1);
            end
            S_BS: begin
                c_start = 1'b1;
                c_x = ppsteer_pkg::CV_W'(r_dx);
                c_y = ppsteer_pkg::CV_W'(r_dy);
            end
            S_SS: begin
                c_start = 1'b1;
                c_rot   = 1'b1;
            end
            S_TS: begin
                c_start = 1'b1;
                c_y = r_num;
                c_x = $signed({5'b0, r_ld, 30'b0});
            end
            default: begin
            end
        endcase
    end

    // Search arithmetic
    always_comb begin
        w_dx  = (ppsteer_pkg::COORD_W+1)'(r_rd_x) - (ppsteer_pkg::COORD_W+1)'(r_vx);
        w_dy  = (ppsteer_pkg::COORD_W+1)'(r_rd_y) - (ppsteer_pkg::COORD_W+1)'(r_vy);
        w_sum = {1'b0, r_sx} + {1'b0, r_sy};
        w_far = (w_sum > (2*ppsteer_pkg::COORD_W+1)'(r_ld2));
    end

    // Bearing minus yaw, wrapped once; steering rounding
    always_comb begin
        w_a0 = (ppsteer_pkg::ANG_W+1)'(c_zo) -
               ((ppsteer_pkg::ANG_W+1)'(r_yaw) <<< 16);
        w_a1 = (w_a0 > (ppsteer_pkg::ANG_W+1)'(ppsteer_pkg::ANG_PI)) ?
               w_a0 - ppsteer_pkg::ANG_TWO_PI : w_a0;
        w_a2 = (w_a1 < -(ppsteer_pkg::ANG_W+1)'(ppsteer_pkg::ANG_PI)) ?
               w_a1 + ppsteer_pkg::ANG_TWO_PI : w_a1;
        w_sin = c_yo;
        w_rnd = ppsteer_pkg::q29_to_q13(c_zo);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    priority if (i_cmd.kind == ppsteer_pkg::K_ORIENT) begin
                        n_state = S_Q1;
                    end else if ((i_cmd.kind == ppsteer_pkg::K_TICK) && r_path_valid &&
                                 r_pos_valid && ({1'b0, r_ss} < r_plen)) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_Q1:   n_state = S_Q2;
            S_Q2:   n_state = S_YS;
            S_YS:   n_state = S_YAW;
            S_YAW:  n_state = c_done ? S_IDLE : S_YAW;
            S_RD:   n_state = S_DIFF;
            S_DIFF: n_state = S_SQR;
            S_SQR:  n_state = S_CMP;
            S_CMP: begin
                priority if (w_far) begin
                    n_state = S_BS;
                end else if ((r_idx + 1'b1) >= r_plen) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_BS:   n_state = S_BEAR;
            S_BEAR: n_state = c_done ? S_SS : S_BEAR;
            S_SS:   n_state = S_SIN;
            S_SIN:  n_state = c_done ? S_TS : S_SIN;
            S_TS:   n_state = S_STEER;
            S_STEER: begin
                if (c_done && (!r_out_valid || i_pop)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Path table write and registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem_x[AW'(i_cmd.idx)] <= i_cmd.cx;
            r_mem_y[AW'(i_cmd.idx)] <= i_cmd.cy;
        end
        r_rd_x <= r_mem_x[r_idx[AW-1:0]];
        r_rd_y <= r_mem_y[r_idx[AW-1:0]];
    end

    // Datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_ld2 <= r_ld * r_ld;
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_Q1) begin
            r_p1 <= r_cmd.qw * r_cmd.qz;
            r_p2 <= r_cmd.qx * r_cmd.qy;
        end
        if (r_state == S_Q2) begin
            r_p3 <= r_cmd.qy * r_cmd.qy;
            r_p4 <= r_cmd.qz * r_cmd.qz;
        end
        if (r_state == S_DIFF) begin
            r_dx <= w_dx;
            r_dy <= w_dy;
            r_mx <= ppsteer_pkg::COORD_W'((w_dx < 0) ? -w_dx : w_dx);
            r_my <= ppsteer_pkg::COORD_W'((w_dy < 0) ? -w_dy : w_dy);
        end
        if (r_state == S_SQR) begin
            r_sx <= r_mx * r_mx;
            r_sy <= r_my * r_my;
        end
        if ((r_state == S_BEAR) && c_done) begin
            r_alpha <= ppsteer_pkg::ANG_W'(w_a2);
        end
        if ((r_state == S_SIN) && c_done) begin
            r_num <= ppsteer_pkg::CV_W'($signed({1'b0, r_wb}) *
                     ppsteer_pkg::COORD_W'(w_sin)) <<< 1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ld         <= ppsteer_pkg::LD_RESET;
            r_wb         <= ppsteer_pkg::WB_RESET;
            r_vx         <= '0;
            r_vy         <= '0;
            r_yaw        <= '0;
            r_path_valid <= 1'b0;
            r_pos_valid  <= 1'b0;
            r_plen       <= '0;
            r_ss         <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
            r_steer      <= '0;
            r_tidx       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == ppsteer_pkg::CFG_LOOKAHEAD) begin
                    r_ld <= i_cfg_data[ppsteer_pkg::LD_W-1:0];
                end else begin
                    r_wb <= i_cfg_data[ppsteer_pkg::WB_W-1:0];
                end
            end
            // Commands finished in the dispatch cycle
            if (o_cmd_pop) begin
                if ((i_cmd.kind == ppsteer_pkg::K_PATH) && i_cmd.last) begin
                    r_plen       <= LW'(32'(i_cmd.idx) + 1);
                    r_path_valid <= 1'b1;
                end
                if (i_cmd.kind == ppsteer_pkg::K_POS) begin
                    r_vx        <= i_cmd.cx;
                    r_vy        <= i_cmd.cy;
                    r_pos_valid <= 1'b1;
                end
                r_idx <= {1'b0, r_ss};
            end
            if ((r_state == S_YAW) && c_done) begin
                r_yaw <= ppsteer_pkg::YAW_W'(w_rnd);
            end
            // Walk the path
            if ((r_state == S_CMP) && !w_far) begin
                r_idx <= r_idx + 1'b1;
            end
            if ((r_state == S_CMP) && w_far) begin
                r_ss <= r_idx[AW-1:0];
            end
            // Result slot: a new result may replace one popped in the same cycle
            priority if ((r_state == S_STEER) && c_done && (!r_out_valid || i_pop)) begin
                r_out_valid <= 1'b1;
                r_tidx      <= ppsteer_pkg::IDX_W'(r_idx);
                priority if (w_rnd > ppsteer_pkg::STEER_MAX) begin
                    r_steer <= ppsteer_pkg::STEER_W'(ppsteer_pkg::STEER_MAX);
                end else if (w_rnd < -ppsteer_pkg::STEER_MAX) begin
                    r_steer <= ppsteer_pkg::STEER_W'(-ppsteer_pkg::STEER_MAX);
                end else begin
                    r_steer <= ppsteer_pkg::STEER_W'(w_rnd);
                end
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/pure_pursuit_steering.sv
// Pure pursuit steering: path table, yaw from quaternion, lookahead search, steering.
// Depends on ppsteer_pkg, ppsteer_front, ppsteer_back (which uses ppsteer_cordic).
//
// Input channel is a queue write: a beat is taken when push is high and full low.
// Each beat is a path point, an orientation, a position or a control tick (i_op).
// Result channel is a queue read: a result is shown while empty is low and is
// taken when pop is high. Only a control tick that finds a lookahead point
// gives a result (steering in Q2.13 and the chosen point's index).
// A two-entry queue sits between the front and the back end, and the result sits in
// an output register, so input is still taken while a result waits to be popped;
// a stalled reader holds the back end only once it has its next result ready.
// In the back end, path point and position beats finish in the dispatch cycle, and an
// orientation passes the quaternion products and the CORDIC. A tick scans the path one
// point at a time through the registered table read, the difference, the squaring
// multipliers and the compare, then uses the shared CORDIC three times.
// Reset (i_rst_n low at a clock edge) empties both queues, clears the
// position and path valid flags and restores the default lookahead and wheel base;
// path table contents are not cleared.
// Configuration writes (i_cfg_we) take effect at once and belong to idle periods.
module pure_pursuit_steering #(
    parameter int PATH_DEPTH   = ppsteer_pkg::PATH_DEPTH_DEF,
    parameter int CORDIC_STEPS = ppsteer_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic                                     i_cfg_index,
    input  logic [ppsteer_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                     push,
    output logic                                     full,
    input  logic [1:0]                               i_op,
    input  logic [ppsteer_pkg::IDX_W-1:0]            i_point_index,
    input  logic                                     i_last_point,
    input  logic signed [ppsteer_pkg::COORD_W-1:0]   i_coord_x,
    input  logic signed [ppsteer_pkg::COORD_W-1:0]   i_coord_y,
    input  logic signed [ppsteer_pkg::QUAT_W-1:0]    i_quat_x,
    input  logic signed [ppsteer_pkg::QUAT_W-1:0]    i_quat_y,
    input  logic signed [ppsteer_pkg::QUAT_W-1:0]    i_quat_z,
    input  logic signed [ppsteer_pkg::QUAT_W-1:0]    i_quat_w,
    output logic                                     empty,
    input  logic                                     pop,
    output logic signed [ppsteer_pkg::STEER_W-1:0]   o_steering,
    output logic [ppsteer_pkg::IDX_W-1:0]            o_target_index
);

    logic              w_cmd_valid, w_cmd_pop;
    ppsteer_pkg::t_cmd w_cmd;

    ppsteer_front #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_op          (i_op),
        .i_point_index (i_point_index),
        .i_last_point  (i_last_point),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_quat_x      (i_quat_x),
        .i_quat_y      (i_quat_y),
        .i_quat_z      (i_quat_z),
        .i_quat_w      (i_quat_w),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    ppsteer_back #(
        .PATH_DEPTH   (PATH_DEPTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_pop      (w_cmd_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_steering     (o_steering),
        .o_target_index (o_target_index)
    );

endmodule
